// ===== rtl/bdlp_pkg.sv =====
package bdlp_pkg;

	// field widths
	localparam int LEVELS_W = 3;
	localparam int BTN_ID_W = 2;
	localparam int KIND_W   = 2;
	localparam int HELD_W   = 16;
	localparam int DEB_W    = 8;
	localparam int LONG_W   = 16;

	// defaults and reset values
	localparam int                NUM_BUTTONS_DEF = 3;
	localparam logic [DEB_W-1:0]  DEBOUNCE_RST    = 8'd20;
	localparam logic [LONG_W-1:0] LONG_PRESS_RST  = 16'd1000;
	localparam logic [HELD_W-1:0] HELD_MAX        = '1;

	// event queue depth, power of two, room for two events per tick
	localparam int EVQ_DEPTH = 4;

	// register map
	localparam int   REG_ADDR_W   = 3;
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_LONG     = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_HELD     = 2'd2,
		PH_LONG     = 2'd3
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PRESS = 2'd0,
		KIND_UNDO  = 2'd1,
		KIND_LONG  = 2'd2
	} ev_kind_t;

	typedef struct packed {
		logic [BTN_ID_W-1:0] button_id;
		ev_kind_t            kind;
		logic [HELD_W-1:0]   held;
		logic                last;
	} event_t;

	// up to two events produced by one tick
	typedef struct packed {
		logic [1:0] count;
		event_t     ev0;
		event_t     ev1;
	} ev_pair_t;

	typedef struct packed {
		logic [DEB_W-1:0]  debounce_ms;
		logic [LONG_W-1:0] long_press_ms;
	} cfg_t;

	// mask of the level bits that belong to real buttons
	function automatic logic [LEVELS_W-1:0] btn_mask(int nb);
		logic [LEVELS_W-1:0] m;
		for (int i = 0; i < LEVELS_W; i++) begin
			m[i] = (i < nb);
		end
		return m;
	endfunction

endpackage

// ===== rtl/bdlp_core.sv =====
module bdlp_core
	import bdlp_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic [LEVELS_W-1:0] levels,
	input  cfg_t                cfg,
	output ev_pair_t            events
);

	localparam logic [LEVELS_W-1:0] BTN_MASK = btn_mask(NUM_BUTTONS);

	phase_t              phase_q, phase_d;
	logic [BTN_ID_W-1:0] owner_q, owner_d;
	logic [HELD_W-1:0]   tick_q, tick_d;
	logic [LEVELS_W-1:0] prev_q;

	logic [LEVELS_W-1:0] lv;
	logic [LEVELS_W-1:0] edges;
	logic [BTN_ID_W-1:0] first_edge;
	logic [HELD_W-1:0]   tick_inc;
	logic                own_pressed;
	event_t              ev_base;

	// level edges, lowest button index wins
	always_comb begin
		lv         = levels & BTN_MASK;
		edges      = (lv ^ prev_q) & BTN_MASK;
		first_edge = '0;
		for (int i = LEVELS_W - 1; i >= 0; i--) begin
			if (edges[i]) begin
				first_edge = BTN_ID_W'(i);
			end
		end
		tick_inc    = (tick_q == HELD_MAX) ? tick_q : tick_q + 1'b1;
		own_pressed = !lv[owner_q];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			owner_q <= '0;
			tick_q  <= '0;
			prev_q  <= BTN_MASK;
		end else if (in_fire) begin
			phase_q <= phase_d;
			owner_q <= owner_d;
			tick_q  <= tick_d;
			prev_q  <= lv;
		end
	end

	// next state and events
	always_comb begin
		phase_d           = phase_q;
		owner_d           = owner_q;
		tick_d            = tick_q;
		ev_base.button_id = owner_q;
		ev_base.kind      = KIND_PRESS;
		ev_base.held      = tick_inc;
		ev_base.last      = 1'b0;
		events.count      = 2'd0;
		events.ev0        = ev_base;
		events.ev1        = ev_base;
		if (in_fire) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (edges != '0) begin
						owner_d = first_edge;
						tick_d  = '0;
						// zero debounce re-reads on the edge tick itself
						if (cfg.debounce_ms == '0) begin
							phase_d = !lv[first_edge] ? PH_HELD : PH_IDLE;
						end else begin
							phase_d = PH_DEBOUNCE;
						end
					end
				end
				PH_DEBOUNCE: begin
					if (tick_inc < {{(HELD_W-DEB_W){1'b0}}, cfg.debounce_ms}) begin
						tick_d = tick_inc;
					end else begin
						tick_d  = '0;
						phase_d = own_pressed ? PH_HELD : PH_IDLE;
					end
				end
				PH_HELD, PH_LONG: begin
					if (!own_pressed) begin
						// release, preceded by press unless a long press was reported
						phase_d = PH_IDLE;
						tick_d  = '0;
						if (phase_q == PH_HELD) begin
							events.count     = 2'd2;
							events.ev1.kind  = KIND_UNDO;
							events.ev1.last  = 1'b1;
						end else begin
							events.count     = 2'd1;
							events.ev0.kind  = KIND_UNDO;
							events.ev0.last  = 1'b1;
						end
					end else if (phase_q == PH_HELD && tick_inc >= cfg.long_press_ms) begin
						phase_d         = PH_LONG;
						tick_d          = tick_inc;
						events.count    = 2'd1;
						events.ev0.kind = KIND_LONG;
						events.ev0.last = 1'b1;
					end else begin
						tick_d = tick_inc;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/bdlp_evq.sv =====
module bdlp_evq
	import bdlp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ev_pair_t push,
	output logic     room,
	output logic     out_valid,
	input  logic     out_ready,
	output event_t   out_event
);

	localparam int PTR_W = $clog2(EVQ_DEPTH);
	localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

	event_t             mem_q [EVQ_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;
	logic [PTR_W-1:0]   wr_ptr_nx;

	assign pop       = out_valid & out_ready;
	assign out_valid = (count_q != '0);
	assign out_event = mem_q[rd_ptr_q];
	assign room      = (count_q <= CNT_W'(EVQ_DEPTH - 2));
	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	// event storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.ev0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.ev1;
		end
	end

endmodule

// ===== rtl/button_debounce_long_press.sv =====
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tdata[2:0] levels
// m_axis    out  m_axis_tvalid / m_axis_tready    tdata button_id, held_ms; tuser kind; tlast
// apb       in   psel, penable, pwrite, pready    debounce_ms at 0x0, long_press_ms at 0x4
//
// one tick is taken per cycle while s_axis_tready is high; its state update and events finish in the accept cycle
// events wait in a four-entry queue, so results show in the cycle after the tick at the earliest
// s_axis_tready drops while the queue has fewer than two free entries
// a tick yields at most two events; the queue drains one per cycle while m_axis_tready is high
// reset returns to idle with all buttons released and the registers at their defaults
module button_debounce_long_press
	import bdlp_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// stream in
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [2:0] levels
	// stream out
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,   // [1:0] button_id, [17:2] held_ms
	output logic [KIND_W-1:0]     m_axis_tuser,   // [1:0] event_kind
	output logic                  m_axis_tlast,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t     cfg_q;
	logic     cfg_wr;
	logic     in_fire;
	ev_pair_t events;
	event_t   out_event;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign in_fire = s_axis_tvalid & s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_PRESS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DEBOUNCE: cfg_q.debounce_ms   <= pwdata[DEB_W-1:0];
				REG_LONG:     cfg_q.long_press_ms <= pwdata[LONG_W-1:0];
				default:      ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[2])
			REG_DEBOUNCE: prdata = {{(32-DEB_W){1'b0}}, cfg_q.debounce_ms};
			REG_LONG:     prdata = {{(32-LONG_W){1'b0}}, cfg_q.long_press_ms};
			default:      prdata = '0;
		endcase
	end

	bdlp_core #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.levels  (s_axis_tdata[LEVELS_W-1:0]),
		.cfg     (cfg_q),
		.events  (events)
	);

	bdlp_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (events),
		.room      (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_event (out_event)
	);

	// output packing
	assign m_axis_tdata = {6'b0, out_event.held, out_event.button_id};
	assign m_axis_tuser = out_event.kind;
	assign m_axis_tlast = out_event.last;

endmodule

// ===== rtl/bdlp_chk.sv =====
module bdlp_chk
	import bdlp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [23:0]       m_axis_tdata,
	input logic [KIND_W-1:0] m_axis_tuser,
	input logic              m_axis_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("output request changed while stalled");

	// button index stays within the three buttons
	a_btn_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("button index out of range");

	// press is never the final event of a tick, release and long press always are
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_PRESS)))
		else $error("tlast does not match event kind");

	// a press is followed at once by the release of the same button
	a_press_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_PRESS |=>
			m_axis_tvalid && m_axis_tuser == KIND_UNDO
			&& m_axis_tdata[17:0] == $past(m_axis_tdata[17:0]))
		else $error("press not followed by matching release");

endmodule

bind button_debounce_long_press bdlp_chk u_bdlp_chk (.*);
